### sv/motion_alarm_event_tracker_macros.svh
// Assertion macros used by the tracker controller.
// Both forms expect aclk and aresetn in scope.
`ifndef MOTION_ALARM_EVENT_TRACKER_MACROS_SVH
`define MOTION_ALARM_EVENT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MAET_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define MAET_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MAET_ASSERT_IMP(lbl, ante, cons)
`define MAET_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/maet_pkg.sv
package maet_pkg;

    // alarm machine modes, encoded as reported on the output
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_PREALARM = 2'd1,
        MODE_ALARM    = 2'd2,
        MODE_ALERT    = 2'd3
    } mode_t;

    // input item kinds (s_tuser)
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_END   = 1'b1;

    // configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_POST      = 1'b1;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
    localparam logic [7:0]  CONS_MAX        = 8'hFF;
    localparam logic [15:0] AVG_MAX         = 16'hFFFF;

    // divider: one quotient bit per cycle
    localparam int DIV_W   = 32;
    localparam int DIV_CNT = $clog2(DIV_W);

    localparam int IN_W  = 48;
    localparam int OUT_W = 232;
    localparam int CFG_W = 16;

    // controller to datapath commands
    typedef struct packed {
        logic step;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
    } dp_status_t;

endpackage

### sv/maet_div.sv
module maet_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [maet_pkg::DIV_W-1:0]  dividend,
    input  logic [maet_pkg::DIV_W-1:0]  divisor,
    output logic                        busy,
    output logic [15:0]                 quotient
);
    import maet_pkg::*;

    logic               busy_reg, busy_next;
    logic [DIV_CNT-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   den_reg, den_next;
    logic [DIV_W:0]     shifted;
    logic [DIV_W:0]     trial;

    // restoring division, dividend shifts out of quo_reg as quotient shifts in
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end else if (busy_reg) begin
            if (!trial[DIV_W]) begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT'(DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // zero divisor gives zero, large quotients saturate
    always_comb begin
        if (den_reg == '0) begin
            quotient = '0;
        end else if (quo_reg[DIV_W-1:16] != '0) begin
            quotient = AVG_MAX;
        end else begin
            quotient = quo_reg[15:0];
        end
    end

    assign busy = busy_reg;

endmodule

### sv/maet_datapath.sv
module maet_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  maet_pkg::ctrl_cmd_t           cmd,
    output maet_pkg::dp_status_t          status,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic [maet_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_tuser,
    input  logic [maet_pkg::IN_W-1:0]     s_tdata,
    output logic [maet_pkg::OUT_W-1:0]    m_tdata
);
    import maet_pkg::*;

    logic [7:0]  thr_reg;
    logic [15:0] post_reg;

    mode_t       mode_reg, mode_next;
    logic [7:0]  cons_reg, cons_next;
    logic [31:0] last_reg, last_next;
    logic        open_reg, open_next;
    logic [31:0] ef_reg, ef_next;
    logic [31:0] eaf_reg, eaf_next;
    logic [31:0] esum_reg, esum_next;
    logic [15:0] emax_reg, emax_next;
    logic [31:0] saf_reg, saf_next;
    logic [31:0] ssum_reg, ssum_next;
    logic [15:0] smax_reg, smax_next;
    logic        opened_reg, opened_next;
    logic        closed_reg, closed_next;
    logic [OUT_W-1:0] out_reg;

    logic        command;
    logic [15:0] score;
    logic [31:0] idx;
    logic [15:0] evt_avg;
    logic [15:0] tot_avg;
    logic        evt_busy;
    logic        tot_busy;

    assign command = s_tuser;
    assign score   = s_tdata[15:0];
    assign idx     = s_tdata[47:16];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THRESHOLD_RESET;
            post_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg  <= cfg_data[7:0];
                REG_POST:      post_reg <= cfg_data;
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    // one alarm machine step per accepted item
    always_comb begin
        logic [7:0]  cons_inc;
        logic [31:0] since;
        logic        clear;
        mode_next   = mode_reg;
        cons_next   = cons_reg;
        last_next   = last_reg;
        open_next   = open_reg;
        ef_next     = ef_reg;
        eaf_next    = eaf_reg;
        esum_next   = esum_reg;
        emax_next   = emax_reg;
        saf_next    = saf_reg;
        ssum_next   = ssum_reg;
        smax_next   = smax_reg;
        opened_next = 1'b0;
        closed_next = 1'b0;
        cons_inc    = (cons_reg != CONS_MAX) ? cons_reg + 8'd1 : cons_reg;
        since       = idx - last_reg;
        clear       = 1'b0;
        if (command == CMD_END) begin
            if (open_reg) begin
                open_next   = 1'b0;
                closed_next = 1'b1;
            end
            mode_next = MODE_IDLE;
            cons_next = '0;
        end else if (score != '0) begin
            // scored frame
            saf_next  = saf_reg + 32'd1;
            ssum_next = ssum_reg + {16'd0, score};
            if (score > smax_reg) begin
                smax_next = score;
            end
            if (mode_reg == MODE_IDLE || mode_reg == MODE_PREALARM) begin
                cons_next = cons_inc;
                if (cons_inc >= thr_reg) begin
                    mode_next   = MODE_ALARM;
                    open_next   = 1'b1;
                    opened_next = 1'b1;
                    clear       = 1'b1;
                end else begin
                    mode_next = MODE_PREALARM;
                end
            end else if (mode_reg == MODE_ALERT) begin
                mode_next = MODE_ALARM;
            end
            if (mode_next == MODE_ALARM) begin
                last_next = idx;
            end
            if (open_next) begin
                ef_next   = (clear ? 32'd0 : ef_reg) + 32'd1;
                eaf_next  = (clear ? 32'd0 : eaf_reg) + 32'd1;
                esum_next = (clear ? 32'd0 : esum_reg) + {16'd0, score};
                if (clear || score > emax_reg) begin
                    emax_next = score;
                end
            end
        end else begin
            // unscored frame
            case (mode_reg)
                MODE_ALARM: begin
                    mode_next = MODE_ALERT;
                end
                MODE_ALERT: begin
                    if (since > {16'd0, post_reg}) begin
                        mode_next = MODE_IDLE;
                        cons_next = '0;
                        if (open_reg) begin
                            open_next   = 1'b0;
                            closed_next = 1'b1;
                        end
                    end else if (open_reg) begin
                        ef_next = ef_reg + 32'd1;
                    end
                end
                MODE_PREALARM: begin
                    mode_next = MODE_IDLE;
                    cons_next = '0;
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            cons_reg   <= '0;
            last_reg   <= '0;
            open_reg   <= 1'b0;
            ef_reg     <= '0;
            eaf_reg    <= '0;
            esum_reg   <= '0;
            emax_reg   <= '0;
            saf_reg    <= '0;
            ssum_reg   <= '0;
            smax_reg   <= '0;
            opened_reg <= 1'b0;
            closed_reg <= 1'b0;
        end else if (cmd.step) begin
            mode_reg   <= mode_next;
            cons_reg   <= cons_next;
            last_reg   <= last_next;
            open_reg   <= open_next;
            ef_reg     <= ef_next;
            eaf_reg    <= eaf_next;
            esum_reg   <= esum_next;
            emax_reg   <= emax_next;
            saf_reg    <= saf_next;
            ssum_reg   <= ssum_next;
            smax_reg   <= smax_next;
            opened_reg <= opened_next;
            closed_reg <= closed_next;
        end
    end

    // averages, both dividers run side by side
    maet_div u_evt_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (esum_reg),
        .divisor  (eaf_reg),
        .busy     (evt_busy),
        .quotient (evt_avg)
    );

    maet_div u_tot_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (ssum_reg),
        .divisor  (saf_reg),
        .busy     (tot_busy),
        .quotient (tot_avg)
    );

    assign status.div_busy = evt_busy | tot_busy;

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {4'd0, tot_avg, smax_reg, ssum_reg, saf_reg,
                        evt_avg, emax_reg, esum_reg, eaf_reg, ef_reg,
                        closed_reg, opened_reg, mode_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

### sv/maet_ctrl.sv
`include "motion_alarm_event_tracker_macros.svh"
module maet_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output maet_pkg::ctrl_cmd_t    cmd,
    input  maet_pkg::dp_status_t   status
);
    import maet_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // sequencing: step, start averages, wait, hand over result
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.step   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // a waiting result is never overwritten
    `MAET_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_reg || m_tready)
    // every step is followed by a divider start
    `MAET_ASSERT_NEXT(a_step_then_div, cmd.step, cmd.div_start)
    // dividers are busy right after being started
    `MAET_ASSERT_NEXT(a_div_runs, cmd.div_start, status.div_busy)

endmodule

### sv/motion_alarm_event_tracker.sv
// Motion alarm event tracker.
// An accepted item steps the alarm machine, then ST_START starts the two side-by-side
// bit-serial average dividers, ST_DIV waits until neither is busy, and ST_DONE loads
// the result once the output is free; a new item is accepted only back in ST_IDLE.
// Reset (aresetn low, synchronous): mode idle, all counts and sums zero,
// alarm_threshold 3, post_event_frames 0, no result pending.
module motion_alarm_event_tracker (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config: index 0 alarm_threshold (data[7:0]), 1 post_event_frames
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [maet_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tuser: command
    input  logic                        s_tuser,
    // s_tdata: score[15:0], frame_index[47:16]
    input  logic [maet_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: machine_state, event_opened, event_closed, event_frames,
    // event_alarm_frames, event_total_score, event_max_score, event_avg_score,
    // stream scored frames, total_score, stream max score, total_avg_score, pad
    output logic [maet_pkg::OUT_W-1:0]  m_tdata
);
    import maet_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    maet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    maet_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule

### test/tb_motion_alarm_event_tracker.sv
module tb_motion_alarm_event_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import maet_pkg::*;

    localparam int REPORT_W = 228;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_ROWS = 28;
    localparam int NUM_PHASES = 7;

    // one report item, first member in the top bits so it maps onto m_tdata[227:0]
    typedef struct packed {
        logic [15:0] total_avg;
        logic [15:0] total_max;
        logic [31:0] total_score;
        logic [31:0] tot_scored_frames;
        logic [15:0] ev_avg;
        logic [15:0] ev_max;
        logic [31:0] ev_score;
        logic [31:0] ev_alarm_frames;
        logic [31:0] ev_frames;
        logic        closed;
        logic        opened;
        mode_t       mode;
    } tracker_report_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    // for ROW_REG rows cmd holds the register index and score the write data
    typedef struct {
        row_kind_t   kind;
        logic        cmd;
        logic [15:0] score;
        logic [31:0] idx;
        bit          known;
        mode_t       k_mode;
        bit          k_open;
        bit          k_close;
    } plan_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = REG_THRESHOLD;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic              s_tuser = CMD_FRAME;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // tracker state as the testbench sees it
    logic [7:0]  thr_cfg = THRESHOLD_RESET;
    logic [15:0] post_cfg = '0;
    mode_t       mode_now = MODE_IDLE;
    logic [7:0]  run_count = '0;
    logic [31:0] last_alarm_idx = '0;
    logic        event_live = 1'b0;
    logic [31:0] ev_frames = '0;
    logic [31:0] ev_alarm_frames = '0;
    logic [31:0] ev_sum = '0;
    logic [15:0] ev_max = '0;
    logic [31:0] st_alarm_frames = '0;
    logic [31:0] st_sum = '0;
    logic [15:0] st_max = '0;

    tracker_report_t reports_due[$];
    plan_row_t       directed_rows[NUM_ROWS];
    int              mismatches = 0;
    int              items_fed = 0;
    bit              idle_on = 1'b1;
    logic [31:0]     next_idx = '0;
    int              rx_hold = 0;

    motion_alarm_event_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // quotient clamped to 16 bits, zero when nothing was counted
    function automatic logic [15:0] mean16(logic [31:0] sum, logic [31:0] cnt);
        logic [31:0] q;
        if (cnt == 0) return '0;
        q = sum / cnt;
        return (q > {16'd0, AVG_MAX}) ? AVG_MAX : q[15:0];
    endfunction

    // advance the alarm machine by one item and return the report it produces
    function automatic tracker_report_t step_alarm_machine(logic cmd, logic [15:0] score,
                                                           logic [31:0] idx);
        tracker_report_t rep;
        logic            opened;
        logic            closed;
        logic [31:0]     since;
        opened = 1'b0;
        closed = 1'b0;
        if (cmd == CMD_END) begin
            if (event_live) begin
                event_live = 1'b0;
                closed = 1'b1;
            end
            mode_now = MODE_IDLE;
            run_count = '0;
        end else if (score != 0) begin
            st_alarm_frames = st_alarm_frames + 1;
            st_sum = st_sum + {16'd0, score};
            if (score > st_max) st_max = score;
            if (mode_now == MODE_IDLE || mode_now == MODE_PREALARM) begin
                if (run_count != CONS_MAX) run_count = run_count + 8'd1;
                if (run_count >= thr_cfg) begin
                    mode_now = MODE_ALARM;
                    event_live = 1'b1;
                    opened = 1'b1;
                    ev_frames = '0;
                    ev_alarm_frames = '0;
                    ev_sum = '0;
                    ev_max = '0;
                end else begin
                    mode_now = MODE_PREALARM;
                end
            end else if (mode_now == MODE_ALERT) begin
                mode_now = MODE_ALARM;
            end
            if (mode_now == MODE_ALARM) last_alarm_idx = idx;
            if (event_live) begin
                ev_frames = ev_frames + 1;
                ev_alarm_frames = ev_alarm_frames + 1;
                ev_sum = ev_sum + {16'd0, score};
                if (score > ev_max) ev_max = score;
            end
        end else begin
            // unscored frame
            case (mode_now)
                MODE_ALARM: begin
                    mode_now = MODE_ALERT;
                end
                MODE_ALERT: begin
                    since = idx - last_alarm_idx;
                    if (since > {16'd0, post_cfg}) begin
                        mode_now = MODE_IDLE;
                        run_count = '0;
                        if (event_live) begin
                            event_live = 1'b0;
                            closed = 1'b1;
                        end
                    end else if (event_live) begin
                        ev_frames = ev_frames + 1;
                    end
                end
                MODE_PREALARM: begin
                    mode_now = MODE_IDLE;
                    run_count = '0;
                end
                default: ;
            endcase
        end
        rep.mode = mode_now;
        rep.opened = opened;
        rep.closed = closed;
        rep.ev_frames = ev_frames;
        rep.ev_alarm_frames = ev_alarm_frames;
        rep.ev_score = ev_sum;
        rep.ev_max = ev_max;
        rep.ev_avg = mean16(ev_sum, ev_alarm_frames);
        rep.tot_scored_frames = st_alarm_frames;
        rep.total_score = st_sum;
        rep.total_max = st_max;
        rep.total_avg = mean16(st_sum, st_alarm_frames);
        return rep;
    endfunction

    // mostly short gaps, a few long ones, none when idling is off
    function automatic int gap_len();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [15:0] rand_score();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'h0001;
        return 16'($urandom_range(1, 65535));
    endfunction

    // index of an unscored frame: next in line, on either side of the
    // post-event window, behind the last alarm frame, or anywhere
    function automatic logic [31:0] quiet_idx();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            4: v = last_alarm_idx + {16'd0, post_cfg};
            5: v = last_alarm_idx + {16'd0, post_cfg} + 1;
            6: v = last_alarm_idx - $urandom_range(1, 100);
            7: v = $urandom();
            default: v = next_idx;
        endcase
        next_idx = v + 1;
        return v;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // hand one item to the block, record what it should report
    task automatic feed(logic cmd, logic [15:0] score, logic [31:0] idx,
                        bit known = 1'b0, mode_t k_mode = MODE_IDLE,
                        bit k_open = 1'b0, bit k_close = 1'b0);
        tracker_report_t due;
        int              gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {idx, score};
        do @(posedge aclk); while (!s_tready);
        due = step_alarm_machine(cmd, score, idx);
        if (known) begin
            due.mode = k_mode;
            due.opened = k_open;
            due.closed = k_close;
        end
        reports_due.insert(reports_due.size(), due);
        items_fed++;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // hold off the sender until every report is back
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_THRESHOLD) thr_cfg = data[7:0];
        else post_cfg = data;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // one random episode: a full alarm, a broken prealarm, noise, end of stream or a drain
    task automatic run_burst();
        int kind;
        int len;
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            len = (thr_cfg == 0) ? $urandom_range(1, 3) : thr_cfg + $urandom_range(0, 3);
            repeat (len) begin
                feed(CMD_FRAME, rand_score(), next_idx);
                next_idx++;
            end
            len = $urandom_range(1, 5);
            repeat (len) feed(CMD_FRAME, 16'd0, quiet_idx());
            if ($urandom_range(0, 3) == 0)
                feed(CMD_END, 16'($urandom_range(0, 65535)), $urandom());
        end else if (kind < 16) begin
            len = (thr_cfg > 1) ? $urandom_range(1, thr_cfg - 1) : 1;
            repeat (len) begin
                feed(CMD_FRAME, rand_score(), next_idx);
                next_idx++;
            end
            feed(CMD_FRAME, 16'd0, quiet_idx());
        end else if (kind < 18) begin
            feed(1'($urandom_range(0, 1)),
                 ($urandom_range(0, 1) == 0) ? 16'd0 : rand_score(), $urandom());
        end else if (kind == 18) begin
            feed(CMD_END, 16'($urandom_range(0, 65535)), $urandom());
        end else begin
            drain();
        end
    endtask

    // receiver: ready with random stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else begin
                m_tready = 1'b1;
                rx_hold = gap_len();
            end
        end
    end

    // compare each report item with the oldest one due
    always @(posedge aclk) begin
        tracker_report_t got;
        tracker_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = tracker_report_t'(m_tdata[REPORT_W-1:0]);
            if (reports_due.size() == 0) begin
                $error("report item with none expected");
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("machine_state", 32'(want.mode), 32'(got.mode));
                check_field("event_opened", 32'(want.opened), 32'(got.opened));
                check_field("event_closed", 32'(want.closed), 32'(got.closed));
                check_field("event_frames", want.ev_frames, got.ev_frames);
                check_field("event_alarm_frames", want.ev_alarm_frames, got.ev_alarm_frames);
                check_field("event_total_score", want.ev_score, got.ev_score);
                check_field("event_max_score", 32'(want.ev_max), 32'(got.ev_max));
                check_field("event_avg_score", 32'(want.ev_avg), 32'(got.ev_avg));
                check_field("stream scored frames", want.tot_scored_frames,
                            got.tot_scored_frames);
                check_field("total_score", want.total_score, got.total_score);
                check_field("stream max score", 32'(want.total_max), 32'(got.total_max));
                check_field("total_avg_score", 32'(want.total_avg), 32'(got.total_avg));
            end
        end
    end

    // main sequence
    initial begin
        logic [7:0]  phase_thr[NUM_PHASES];
        logic [15:0] phase_post[NUM_PHASES];
        int          phase_end;

        directed_rows = '{
            // end of stream right after reset, ignored fields at their maximum
            '{ROW_ITEM, CMD_END,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd0,         1'b1, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'hFFFF, 32'd1,         1'b1, MODE_PREALARM, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0001, 32'd2,         1'b1, MODE_PREALARM, 1'b0, 1'b0},
            // unscored frame breaks the prealarm run
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd3,         1'b1, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h8000, 32'd4,         1'b0, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h7FFF, 32'd5,         1'b0, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'hFFFF, 32'd6,         1'b1, MODE_ALARM,    1'b1, 1'b0},
            // alarm to alert, frame not counted in the event
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd7,         1'b1, MODE_ALERT,    1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h1234, 32'd8,         1'b1, MODE_ALARM,    1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd8,         1'b0, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd8,         1'b1, MODE_ALERT,    1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd10,        1'b1, MODE_IDLE,     1'b0, 1'b1},
            '{ROW_ITEM, CMD_FRAME, 16'h0003, 32'hFFFF_FFFD, 1'b0, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0003, 32'hFFFF_FFFE, 1'b0, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0003, 32'hFFFF_FFFF, 1'b1, MODE_ALARM,    1'b1, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'hFFFF_FFFF, 1'b0, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'hFFFF_FFFF, 1'b1, MODE_ALERT,    1'b0, 1'b0},
            // end of stream closes the open event
            '{ROW_ITEM, CMD_END,   16'h0000, 32'd0,         1'b1, MODE_IDLE,     1'b0, 1'b1},
            '{ROW_REG,  REG_THRESHOLD, 16'd0, 32'd0,        1'b0, MODE_IDLE,     1'b0, 1'b0},
            '{ROW_REG,  REG_POST,  16'hFFFF, 32'd0,         1'b0, MODE_IDLE,     1'b0, 1'b0},
            // zero threshold: first scored frame opens an event
            '{ROW_ITEM, CMD_FRAME, 16'h0009, 32'd1000,      1'b1, MODE_ALARM,    1'b1, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd1001,      1'b0, MODE_IDLE,     1'b0, 1'b0},
            // last frame inside the widest post-event window, then the first outside
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd66535,     1'b1, MODE_ALERT,    1'b0, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd66536,     1'b1, MODE_IDLE,     1'b0, 1'b1},
            '{ROW_ITEM, CMD_FRAME, 16'h0004, 32'd2000,      1'b1, MODE_ALARM,    1'b1, 1'b0},
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd2000,      1'b1, MODE_ALERT,    1'b0, 1'b0},
            // backwards index looks far away
            '{ROW_ITEM, CMD_FRAME, 16'h0000, 32'd1999,      1'b1, MODE_IDLE,     1'b0, 1'b1}
        };
        phase_thr  = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd5, 8'd3, 8'd0};
        phase_post = '{16'd2, 16'd0, 16'hFFFF, 16'd0, 16'd7, 16'd300, 16'd0};
        phase_thr[NUM_PHASES-1]  = 8'($urandom_range(0, 8));
        phase_post[NUM_PHASES-1] = 16'($urandom_range(0, 65535));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].cmd, directed_rows[i].score);
            else
                feed(directed_rows[i].cmd, directed_rows[i].score, directed_rows[i].idx,
                     directed_rows[i].known, directed_rows[i].k_mode,
                     directed_rows[i].k_open, directed_rows[i].k_close);
        end

        // random phases, each under its own register setting
        next_idx = $urandom();
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_on = (p % 3 != 1);
            write_reg(REG_THRESHOLD, {8'd0, phase_thr[p]});
            write_reg(REG_POST, phase_post[p]);
            phase_end = items_fed + ((phase_thr[p] == CONS_MAX) ? 330 : 120);
            while (items_fed < phase_end) run_burst();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
